// ===== sv/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF          = 16;
  localparam int PAYLOAD_WIDTH_DEF  = 32;
  localparam int PRIORITY_WIDTH_DEF = 32;

  // Fixed port widths
  localparam int PAY_PORT_W = 32;
  localparam int PRI_PORT_W = 32;

  typedef enum logic [1:0] {
    OP_NOP = 2'd0,
    OP_ENQ = 2'd1,
    OP_DEQ = 2'd2,
    OP_CLR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
    logic clr;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/spq_cell.sv =====
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cell_ctl_t                 ctl,
  input  wire logic [PAYLOAD_WIDTH-1:0]  new_pay,
  input  wire logic [PRIORITY_WIDTH-1:0] new_pri,
  // left neighbour (towards the head)
  input  wire logic                      left_ins,
  input  wire logic                      left_valid,
  input  wire logic [PAYLOAD_WIDTH-1:0]  left_pay,
  input  wire logic [PRIORITY_WIDTH-1:0] left_pri,
  // right neighbour (towards the tail)
  input  wire logic                      right_valid,
  input  wire logic [PAYLOAD_WIDTH-1:0]  right_pay,
  input  wire logic [PRIORITY_WIDTH-1:0] right_pri,
  output logic                           ins,
  output logic                           valid,
  output logic [PAYLOAD_WIDTH-1:0]       pay,
  output logic [PRIORITY_WIDTH-1:0]      pri
);

  // New entry lands at or before this cell: empty, or strictly larger priority
  // (equal priority keeps the new entry behind).
  assign ins = !valid || ($signed(pri) > $signed(new_pri));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.enq) begin
      if (left_ins) begin
        valid <= left_valid;
        pay   <= left_pay;
        pri   <= left_pri;
      end else if (ins) begin
        valid <= 1'b1;
        pay   <= new_pay;
        pri   <= new_pri;
      end
    end else if (ctl.deq) begin
      valid <= right_valid;
      pay   <= right_pay;
      pri   <= right_pri;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sorted_priority_queue.sv =====
`default_nettype none
// Sorted priority queue, a row of DEPTH cells kept in ascending priority.
// Input channel (in_valid/in_ready): opcode, payload_in, priority_in.
//   nop reports state, enqueue inserts behind all equal priorities,
//   dequeue takes the head, clear empties the queue.
// Output channel (out_valid/out_ready): one result per input transfer with
//   status, taken payload, head payload/priority, entry count, empty flag.
// Latency: the result is registered and shows the cycle after the input
//   transfer. Throughput: one item per cycle; every cell compares the new
//   priority against its own in parallel and shifts in the same edge.
// When the receiver stalls, the result holds and in_ready drops until the
//   result transfers; a new item may enter in the cycle the result leaves.
// Enqueue on a full queue is dropped (status 2); dequeue on an empty one
//   leaves state alone (status 1).
// Reset (rst, synchronous) clears every cell's valid bit and the count; no
//   clearing pass is needed. Payloads and priorities are kept in their low
//   PAYLOAD_WIDTH / PRIORITY_WIDTH bits and come out zero-extended.

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH          = DEPTH_DEF,
  parameter int PAYLOAD_WIDTH  = PAYLOAD_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF,
  localparam int CNT_W         = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            opcode,
  input  wire logic [PAY_PORT_W-1:0] payload_in,
  input  wire logic [PRI_PORT_W-1:0] priority_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 status,
  output logic [PAY_PORT_W-1:0]      taken_payload,
  output logic [PAY_PORT_W-1:0]      head_payload,
  output logic [PRI_PORT_W-1:0]      head_priority,
  output logic [CNT_W-1:0]           entry_total,
  output logic                       is_empty
);

  // Cell row state
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0]          cell_ins;
  logic [PAYLOAD_WIDTH-1:0]  cell_pay [DEPTH];
  logic [PRIORITY_WIDTH-1:0] cell_pri [DEPTH];

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic                      in_fire;
  logic                      full;
  logic                      empty;
  op_t                       op;
  cell_ctl_t                 ctl;
  logic [PAYLOAD_WIDTH-1:0]  new_pay;
  logic [PRIORITY_WIDTH-1:0] new_pri;
  logic [1:0]                status_next;
  logic [PAY_PORT_W-1:0]     taken_next;

  assign op       = op_t'(opcode);
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // Keep the low bits of the port fields, zero-filling any wider store
  always_comb begin
    for (int b = 0; b < PAYLOAD_WIDTH; b++) begin
      new_pay[b] = (b < PAY_PORT_W) ? payload_in[b % PAY_PORT_W] : 1'b0;
    end
    for (int b = 0; b < PRIORITY_WIDTH; b++) begin
      new_pri[b] = (b < PRI_PORT_W) ? priority_in[b % PRI_PORT_W] : 1'b0;
    end
  end

  // Command decode; full/empty cases turn into no cell action
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = ST_OK;
    taken_next  = '0;
    case (op)
      OP_ENQ: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.enq    = in_fire;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEQ: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.deq    = in_fire;
          count_next = count - CNT_W'(1);
          for (int b = 0; b < PAY_PORT_W; b++) begin
            taken_next[b] = (b < PAYLOAD_WIDTH) ? cell_pay[0][b % PAYLOAD_WIDTH] : 1'b0;
          end
        end
      end
      OP_CLR: begin
        ctl.clr    = in_fire;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Row of cells: left is the head side, right the tail side
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      l_ins;
    logic                      l_valid;
    logic [PAYLOAD_WIDTH-1:0]  l_pay;
    logic [PRIORITY_WIDTH-1:0] l_pri;
    logic                      r_valid;
    logic [PAYLOAD_WIDTH-1:0]  r_pay;
    logic [PRIORITY_WIDTH-1:0] r_pri;

    if (i == 0) begin : g_head
      assign l_ins   = 1'b0;
      assign l_valid = 1'b0;
      assign l_pay   = new_pay;
      assign l_pri   = new_pri;
    end else begin : g_mid_l
      assign l_ins   = cell_ins[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_pay   = cell_pay[i-1];
      assign l_pri   = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_pay   = cell_pay[i];
      assign r_pri   = cell_pri[i];
    end else begin : g_mid_r
      assign r_valid = cell_valid[i+1];
      assign r_pay   = cell_pay[i+1];
      assign r_pri   = cell_pri[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH  (PAYLOAD_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_pay     (new_pay),
      .new_pri     (new_pri),
      .left_ins    (l_ins),
      .left_valid  (l_valid),
      .left_pay    (l_pay),
      .left_pri    (l_pri),
      .right_valid (r_valid),
      .right_pay   (r_pay),
      .right_pri   (r_pri),
      .ins         (cell_ins[i]),
      .valid       (cell_valid[i]),
      .pay         (cell_pay[i]),
      .pri         (cell_pri[i])
    );
  end

  // Count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        count         <= count_next;
        out_valid     <= 1'b1;
        status        <= status_next;
        taken_payload <= taken_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Cells only change on an input transfer, and none is taken while a
  // result waits, so the head is read straight from the first cell.
  always_comb begin
    for (int b = 0; b < PAY_PORT_W; b++) begin
      head_payload[b] = (b < PAYLOAD_WIDTH) ?
                        (cell_valid[0] & cell_pay[0][b % PAYLOAD_WIDTH]) : 1'b0;
    end
    for (int b = 0; b < PRI_PORT_W; b++) begin
      head_priority[b] = (b < PRIORITY_WIDTH) ?
                         (cell_valid[0] & cell_pri[0][b % PRIORITY_WIDTH]) : 1'b0;
    end
  end

  assign entry_total = count;
  assign is_empty    = empty;

  // Count tracks the number of occupied cells
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count))
    else $error("entry count differs from occupied cells");

  // Occupied cells form an unbroken run from the head
  a_cells_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in occupied cells");

  // Dequeue on empty leaves the queue empty and flags it
  a_deq_empty: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_DEQ && empty) |=> (status == ST_EMPTY && count == '0))
    else $error("dequeue on empty mishandled");

  // Enqueue on full is dropped without changing the count
  a_enq_full: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_ENQ && full) |=> (status == ST_FULL && full))
    else $error("enqueue on full mishandled");

endmodule

`default_nettype wire

// ===== tb/sv/spq_checker.sv =====
`default_nettype none

// Watches both channels of the sorted priority queue, keeps its own copy of
// the queue contents and checks each result against the oldest prediction.
module spq_checker
  import spq_pkg::*;
#(
  localparam int CNT_W = $clog2(DEPTH_DEF + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [1:0]            opcode,
  input  wire logic [PAY_PORT_W-1:0] payload_in,
  input  wire logic [PRI_PORT_W-1:0] priority_in,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [1:0]            status,
  input  wire logic [PAY_PORT_W-1:0] taken_payload,
  input  wire logic [PAY_PORT_W-1:0] head_payload,
  input  wire logic [PRI_PORT_W-1:0] head_priority,
  input  wire logic [CNT_W-1:0]      entry_total,
  input  wire logic                  is_empty,
  output int                         err_count,
  output int                         pending,
  output int                         results_seen,
  output int                         full_drops,
  output int                         empty_deqs
);

  typedef struct {
    status_t                st;
    logic [PAY_PORT_W-1:0]  taken;
    logic [PAY_PORT_W-1:0]  hpay;
    logic [PRI_PORT_W-1:0]  hpri;
    logic [CNT_W-1:0]       total;
    logic                   empty;
  } queue_view_t;

  logic [PAY_PORT_W-1:0]        pay_q [DEPTH_DEF];
  logic signed [PRI_PORT_W-1:0] pri_q [DEPTH_DEF];
  int                           held;
  queue_view_t                  view_q [$];

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: result %0d: %s got %h want %h", $realtime, results_seen, what, got, want);
    err_count++;
  endtask

  // Applies one operation to the shadow queue and returns what the block
  // should show afterwards.
  function automatic queue_view_t apply_op(op_t op, logic [PAY_PORT_W-1:0] pay,
                                           logic signed [PRI_PORT_W-1:0] pri);
    queue_view_t v;
    int pos;
    v.st    = ST_OK;
    v.taken = '0;
    case (op)
      OP_ENQ: begin
        if (held >= DEPTH_DEF) begin
          v.st = ST_FULL;
          full_drops++;
        end else begin
          // behind every entry of lower or equal priority
          pos = 0;
          while (pos < held && pri_q[pos] <= pri) pos++;
          for (int i = held; i > pos; i--) begin
            pay_q[i] = pay_q[i-1];
            pri_q[i] = pri_q[i-1];
          end
          pay_q[pos] = pay;
          pri_q[pos] = pri;
          held++;
        end
      end
      OP_DEQ: begin
        if (held == 0) begin
          v.st = ST_EMPTY;
          empty_deqs++;
        end else begin
          v.taken = pay_q[0];
          held--;
          for (int i = 0; i < held; i++) begin
            pay_q[i] = pay_q[i+1];
            pri_q[i] = pri_q[i+1];
          end
        end
      end
      OP_CLR: held = 0;
      default: ;
    endcase
    v.hpay  = (held != 0) ? pay_q[0] : '0;
    v.hpri  = (held != 0) ? pri_q[0] : '0;
    v.total = CNT_W'(held);
    v.empty = (held == 0);
    return v;
  endfunction

  // Result side first: results are registered, so a result leaving at this
  // edge always belongs to an earlier transfer.
  always @(posedge clk) begin
    queue_view_t want;
    if (rst) begin
      held         = 0;
      err_count    = 0;
      results_seen = 0;
      full_drops   = 0;
      empty_deqs   = 0;
      view_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (view_q.size() == 0) begin
          report("result with nothing outstanding, status", 32'(status), '0);
        end else begin
          want = view_q.pop_front();
          if (status !== want.st)
            report("status", 32'(status), 32'(want.st));
          if (taken_payload !== want.taken)
            report("taken_payload", taken_payload, want.taken);
          if (head_payload !== want.hpay)
            report("head_payload", head_payload, want.hpay);
          if (head_priority !== want.hpri)
            report("head_priority", head_priority, want.hpri);
          if (entry_total !== want.total)
            report("entry_total", 32'(entry_total), 32'(want.total));
          if (is_empty !== want.empty)
            report("is_empty", 32'(is_empty), 32'(want.empty));
        end
      end
      if (in_valid && in_ready)
        view_q.push_back(apply_op(op_t'(opcode), payload_in, priority_in));
      pending <= view_q.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

// Stimulus and verdict for the sorted priority queue. Checking lives in
// spq_checker; this module only makes traffic on both channels.
//
// Traffic plan:
//   - a short directed run: empty queue queries, extreme priorities and
//     payloads, ties at zero and at the top priority, clear with entries
//   - random blocks in several flavours: fill (mostly enqueues, runs into
//     the full drop), drain (mostly dequeues, hits empty), mixed, and
//     tie-heavy (few distinct priorities, checks FIFO order among equals)
//   - now and then a long receiver hold while the sender keeps offering,
//     and a pause until every result is back
module tb_top
  import spq_pkg::*;
;

  localparam int          CNT_W       = $clog2(DEPTH_DEF + 1);
  localparam int          ITEM_TARGET = 1150;
  localparam int          RX_HOLD     = 60;
  localparam int unsigned CYCLE_LIMIT = 500000;

  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;
  localparam int MODE_TIES  = 3;

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode      = OP_NOP;
  logic [PAY_PORT_W-1:0] payload_in  = '0;
  logic [PRI_PORT_W-1:0] priority_in = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [1:0]            status;
  logic [PAY_PORT_W-1:0] taken_payload;
  logic [PAY_PORT_W-1:0] head_payload;
  logic [PRI_PORT_W-1:0] head_priority;
  logic [CNT_W-1:0]      entry_total;
  logic                  is_empty;

  int err_count, pending, results_seen, full_drops, empty_deqs;

  // shared between sender and receiver, written only by the sender side
  logic no_idle  = 1'b0;
  int   hold_seq = 0;

  int          items_sent = 0;
  int          op_seen [4];
  logic [31:0] tie_base;

  sorted_priority_queue dut (.*);
  spq_checker           chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  return r < 85 ? OP_ENQ : r < 95 ? OP_DEQ : r < 98 ? OP_NOP : OP_CLR;
      MODE_DRAIN: return r < 80 ? OP_DEQ : r < 95 ? OP_ENQ : OP_NOP;
      default:    return r < 47 ? OP_ENQ : r < 87 ? OP_DEQ : r < 97 ? OP_NOP : OP_CLR;
    endcase
  endfunction

  // tie-heavy blocks draw from three neighbouring values
  function automatic logic [31:0] pick_priority(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == MODE_TIES) return tie_base + $urandom_range(0, 2);
    if (r < 3)  return 32'h7FFF_FFFF;
    if (r < 6)  return 32'h8000_0000;
    if (r < 8)  return 32'h0000_0000;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_payload();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 6) return '1;
    return $urandom;
  endfunction

  // Offer one item and hold it until the transfer; then maybe idle a while.
  task automatic send_item(op_t op, logic [31:0] pay, logic [31:0] pri);
    int g;
    in_valid    <= 1'b1;
    opcode      <= op;
    payload_in  <= pay;
    priority_in <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    op_seen[int'(op)]++;
    g = no_idle ? 0 : pick_gap();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random ready pattern, plus a long hold each time the sender
  // bumps hold_seq.
  initial begin : rx_side
    int holds_done, n;
    holds_done = 0;
    @(posedge clk);
    forever begin
      if (hold_seq != holds_done) begin
        holds_done = hold_seq;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else begin
        n = no_idle ? 0 : pick_gap();
        if (n == 0) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int blk, mode, len;
    blk = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, extremes, ties, clear with entries
    send_item(OP_NOP, 32'hDEAD_BEEF, 32'h1234_5678);
    send_item(OP_DEQ, '0, '0);                          // dequeue on empty
    send_item(OP_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF);    // top priority
    send_item(OP_ENQ, 32'h0000_0000, 32'h8000_0000);    // bottom priority
    send_item(OP_ENQ, 32'h5A5A_5A5A, 32'h0000_0000);
    send_item(OP_ENQ, 32'hA5A5_A5A5, 32'h0000_0000);    // tie, goes behind
    send_item(OP_ENQ, 32'h0000_0001, 32'h7FFF_FFFF);    // tie at the top
    send_item(OP_ENQ, 32'h8000_0000, 32'hFFFF_FFFF);    // minus one LSB
    send_item(OP_NOP, 32'hFFFF_FFFF, 32'h8000_0000);    // fields ignored
    send_item(OP_DEQ, 32'h1111_1111, 32'h2222_2222);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_DEQ, '0, '0);
    send_item(OP_CLR, 32'hFFFF_FFFF, 32'h7FFF_FFFF);    // clear with entries
    send_item(OP_DEQ, '0, '0);                          // empty again
    send_item(OP_ENQ, 32'h0BAD_F00D, 32'h0001_0000);    // priority 65536
    send_item(OP_DEQ, '0, '0);
    drain_results();

    // random blocks
    while (items_sent < ITEM_TARGET) begin
      blk++;
      if (blk == 1 || blk % 24 == 0) begin
        // long receiver hold while enqueues keep coming: output stalls,
        // in_ready drops, and the queue runs past full
        mode = MODE_FILL;
        len  = 24;
        no_idle  <= 1'b1;
        hold_seq <= hold_seq + 1;
      end else begin
        mode = $urandom_range(MODE_FILL, MODE_TIES);
        len  = $urandom_range(8, 30);
        no_idle <= ($urandom_range(0, 4) == 0);
        if (blk % 13 == 0) drain_results();
      end
      tie_base = pick_priority(MODE_MIX);
      repeat (len) send_item(pick_op(mode), pick_payload(), pick_priority(mode));
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d transfers: %0d nop, %0d enqueue, %0d dequeue, %0d clear; %0d results checked.",
             items_sent, op_seen[OP_NOP], op_seen[OP_ENQ], op_seen[OP_DEQ], op_seen[OP_CLR],
             results_seen);
    $display("Full-queue drops %0d, empty dequeues %0d, long receiver holds %0d.",
             full_drops, empty_deqs, hold_seq);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
